### design/bges_pkg.sv
// types and constants shared by the button gesture event scanner
`timescale 1ns / 1ps
`default_nettype none

package bges_pkg;

   localparam int BUTTONS     = 4;
   localparam int COUNT_WIDTH = 16;
   localparam int PORT_W      = 8;
   localparam int PIN_SEL_W   = $clog2(PORT_W);
   localparam int BTN_IDX_W   = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;

   // configuration register map
   localparam int CSR_COUNT        = 2 + BUTTONS;
   localparam int CSR_IDX_W        = $clog2(CSR_COUNT);
   localparam int CSR_DATA_W       = COUNT_WIDTH;
   localparam int CSR_PIN_SEL_BASE = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_LONG_PRESS   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_DOUBLE_CLICK = CSR_IDX_W'(1);

   localparam logic [COUNT_WIDTH-1:0] CNT_MAX       = {COUNT_WIDTH{1'b1}};
   localparam logic [COUNT_WIDTH-1:0] LONG_PRESS_RST = COUNT_WIDTH'(100);
   localparam logic [COUNT_WIDTH-1:0] DOUBLE_CLICK_RST = COUNT_WIDTH'(30);

   // button count held one bit wider than an index, for wrap compares
   localparam logic [BTN_IDX_W:0] BTN_CNT = (BTN_IDX_W + 1)'(BUTTONS);

   typedef logic [BTN_IDX_W-1:0] btn_idx_type;
   typedef logic [PORT_W-1:0]    port_type;

   typedef enum logic {
      CMD_SCAN  = 1'b0,
      CMD_FETCH = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      EV_NONE     = 3'd0,
      EV_PRESSED  = 3'd1,
      EV_LONG     = 3'd2,
      EV_RELEASED = 3'd3,
      EV_DOUBLE   = 3'd4
   } event_code_type;

endpackage

`default_nettype wire

### design/button_gesture_event_scanner_core.sv
// button gesture event scanner: scan ticks update buttons, fetches return events
`timescale 1ns / 1ps
`default_nettype none
// a fetch word is held in the input register, then in the result register that drives rsp_
// throughput: one word per cycle; a scan never stalls, a fetch waits only on a full result reg
// reset: synchronous active high, clears button state, pending events, pointer and valids,
// and loads the register defaults (long press 100, double click 30, pin select k = k)

module button_gesture_event_scanner_core (
   input  wire                                 clock,
   input  wire                                 reset,
   // request channel
   input  wire                                 req_valid,
   output logic                                req_ready,
   input  bges_pkg::cmd_type                   req_cmd,
   input  bges_pkg::port_type                  req_port_sample,
   // result channel
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output logic                                rsp_event_valid,
   output bges_pkg::btn_idx_type               rsp_button_index,
   output bges_pkg::event_code_type            rsp_event_code,
   // register write port
   input  wire                                 csr_write_enable,
   input  wire  [bges_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire  [bges_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   import bges_pkg::*;

   // configuration registers
   logic [COUNT_WIDTH-1:0] long_press_ff;
   logic [COUNT_WIDTH-1:0] double_click_ff;
   logic [PIN_SEL_W-1:0]   pin_sel_ff [BUTTONS];

   // input register stage
   logic     stg_valid_ff;
   cmd_type  stg_cmd_ff;
   port_type stg_port_ff;
   logic     stg_go;

   // per button state
   logic                   level_ff   [BUTTONS];
   logic [COUNT_WIDTH-1:0] hold_ff    [BUTTONS];
   logic [COUNT_WIDTH-1:0] gap_ff     [BUTTONS];
   event_code_type         pending_ff [BUTTONS];
   btn_idx_type            ptr_ff;

   logic                   level_in   [BUTTONS];
   logic [COUNT_WIDTH-1:0] hold_in    [BUTTONS];
   logic [COUNT_WIDTH-1:0] gap_in     [BUTTONS];
   event_code_type         pending_in [BUTTONS];
   btn_idx_type            ptr_in;

   // scan results per button
   logic                   scan_level [BUTTONS];
   logic [COUNT_WIDTH-1:0] scan_hold  [BUTTONS];
   logic [COUNT_WIDTH-1:0] scan_gap   [BUTTONS];
   event_code_type         scan_ev    [BUTTONS];

   // round-robin pick
   logic                   pick_found;
   btn_idx_type            pick_idx;
   btn_idx_type            pick_next;
   logic [BTN_IDX_W:0]     cand_sum   [BUTTONS];
   btn_idx_type            cand_idx   [BUTTONS];
   logic [BTN_IDX_W:0]     next_sum;

   // result register
   logic           rsp_valid_ff;
   logic           rsp_event_valid_ff;
   btn_idx_type    rsp_button_index_ff;
   event_code_type rsp_event_code_ff;

   // the staged word moves on unless it is a fetch facing a full result register
   assign stg_go    = stg_valid_ff &&
                      ((stg_cmd_ff == CMD_SCAN) || !rsp_valid_ff || rsp_ready);
   assign req_ready = !stg_valid_ff || stg_go;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_valid  = rsp_event_valid_ff;
   assign rsp_button_index = rsp_button_index_ff;
   assign rsp_event_code   = rsp_event_code_ff;

   // scan update, one independent slice per button
   always_comb begin
      logic                   now;
      logic                   press;
      logic                   rel;
      logic [COUNT_WIDTH-1:0] hold_base;
      logic [COUNT_WIDTH-1:0] gap_base;
      for (int k = 0; k < BUTTONS; k++) begin
         // active low pins
         now   = !stg_port_ff[pin_sel_ff[k]];
         press = now && !level_ff[k];
         rel   = !now && level_ff[k];

         hold_base = press ? '0 : hold_ff[k];
         if (now && (hold_base != CNT_MAX)) begin
            scan_hold[k] = hold_base + COUNT_WIDTH'(1);
         end else begin
            scan_hold[k] = hold_base;
         end

         gap_base = rel ? '0 : gap_ff[k];
         if (!now && (gap_base != CNT_MAX)) begin
            scan_gap[k] = gap_base + COUNT_WIDTH'(1);
         end else begin
            scan_gap[k] = gap_base;
         end

         // later conditions override earlier ones, newer event wins
         scan_ev[k] = pending_ff[k];
         if (press) begin
            scan_ev[k] = EV_PRESSED;
         end
         if (now && (scan_hold[k] == long_press_ff)) begin
            scan_ev[k] = EV_LONG;
         end
         if (rel) begin
            if ((gap_ff[k] != '0) && (gap_ff[k] <= double_click_ff)) begin
               scan_ev[k] = EV_DOUBLE;
            end else begin
               scan_ev[k] = EV_RELEASED;
            end
         end

         scan_level[k] = now;
      end
   end

   // round-robin search from the poll pointer, nearest candidate wins
   always_comb begin
      pick_found = 1'b0;
      pick_idx   = '0;
      for (int n = 0; n < BUTTONS; n++) begin
         cand_sum[n] = {1'b0, ptr_ff} + (BTN_IDX_W + 1)'(n);
         if (cand_sum[n] >= BTN_CNT) begin
            cand_sum[n] = cand_sum[n] - BTN_CNT;
         end
         cand_idx[n] = cand_sum[n][BTN_IDX_W-1:0];
      end
      for (int n = BUTTONS - 1; n >= 0; n--) begin
         if (pending_ff[cand_idx[n]] != EV_NONE) begin
            pick_found = 1'b1;
            pick_idx   = cand_idx[n];
         end
      end
      next_sum = {1'b0, pick_idx} + (BTN_IDX_W + 1)'(1);
      if (next_sum >= BTN_CNT) begin
         next_sum = next_sum - BTN_CNT;
      end
      pick_next = next_sum[BTN_IDX_W-1:0];
   end

   // next state select
   always_comb begin
      ptr_in = ptr_ff;
      for (int k = 0; k < BUTTONS; k++) begin
         level_in[k]   = level_ff[k];
         hold_in[k]    = hold_ff[k];
         gap_in[k]     = gap_ff[k];
         pending_in[k] = pending_ff[k];
      end
      if (stg_cmd_ff == CMD_SCAN) begin
         for (int k = 0; k < BUTTONS; k++) begin
            level_in[k]   = scan_level[k];
            hold_in[k]    = scan_hold[k];
            gap_in[k]     = scan_gap[k];
            pending_in[k] = scan_ev[k];
         end
      end else if (pick_found) begin
         pending_in[pick_idx] = EV_NONE;
         ptr_in               = pick_next;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         long_press_ff   <= LONG_PRESS_RST;
         double_click_ff <= DOUBLE_CLICK_RST;
         for (int k = 0; k < BUTTONS; k++) begin
            pin_sel_ff[k] <= PIN_SEL_W'(k);
         end
      end else if (csr_write_enable) begin
         if (csr_index == CSR_LONG_PRESS) begin
            long_press_ff <= csr_write_data[COUNT_WIDTH-1:0];
         end
         if (csr_index == CSR_DOUBLE_CLICK) begin
            double_click_ff <= csr_write_data[COUNT_WIDTH-1:0];
         end
         for (int k = 0; k < BUTTONS; k++) begin
            if (csr_index == CSR_IDX_W'(CSR_PIN_SEL_BASE + k)) begin
               pin_sel_ff[k] <= csr_write_data[PIN_SEL_W-1:0];
            end
         end
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else if (req_ready) begin
         stg_valid_ff <= req_valid;
      end
      if (req_ready && req_valid) begin
         stg_cmd_ff  <= req_cmd;
         stg_port_ff <= req_port_sample;
      end
   end

   // button state and poll pointer
   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
         for (int k = 0; k < BUTTONS; k++) begin
            level_ff[k]   <= 1'b0;
            hold_ff[k]    <= '0;
            gap_ff[k]     <= '0;
            pending_ff[k] <= EV_NONE;
         end
      end else if (stg_go) begin
         ptr_ff <= ptr_in;
         for (int k = 0; k < BUTTONS; k++) begin
            level_ff[k]   <= level_in[k];
            hold_ff[k]    <= hold_in[k];
            gap_ff[k]     <= gap_in[k];
            pending_ff[k] <= pending_in[k];
         end
      end
   end

   // result register, only fetch words produce a result
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (stg_go && (stg_cmd_ff == CMD_FETCH)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (stg_go && (stg_cmd_ff == CMD_FETCH)) begin
         rsp_event_valid_ff  <= pick_found;
         rsp_button_index_ff <= pick_found ? pick_idx : '0;
         rsp_event_code_ff   <= pick_found ? pending_ff[pick_idx] : EV_NONE;
      end
   end

endmodule

`default_nettype wire
